// ===== hw/rtl/smt_pkg.sv =====
// Shared types and constants for the set membership table.
package smt_pkg;

    // Default table size
    localparam int CAPACITY = 64;

    localparam int KEY_W = 32;
    localparam int CMD_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Probe token handed from cell to cell during a scan
    typedef struct packed {
        logic active;     // token is at this point of the chain
        logic hit;        // an earlier cell holds the key
        logic free_seen;  // an earlier cell is free
    } probe_t;

    // Update broadcast to every cell at the end of a scan
    typedef struct packed {
        logic insert_en;  // the marked free cell takes the key
        logic erase_en;   // the marked matching cell is cleared
    } commit_t;

endpackage

// ===== hw/rtl/smt_cell.sv =====
// One table entry: stored key, valid bit and the marks left by the passing probe.
module smt_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  smt_pkg::probe_t             probe_in,
    output smt_pkg::probe_t             probe_out,
    input  logic [smt_pkg::KEY_W-1:0]   key,
    input  smt_pkg::commit_t            commit
);

    logic [smt_pkg::KEY_W-1:0] value_reg;
    logic                      valid_reg;
    logic                      mark_hit_reg;
    logic                      mark_free_reg;
    smt_pkg::probe_t           probe_reg;
    logic                      match;

    // Local compare against the broadcast key
    assign match = valid_reg && (value_reg == key);

    // Probe stage and marks: this cell is the first free one or the matching one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg     <= '0;
            mark_hit_reg  <= 1'b0;
            mark_free_reg <= 1'b0;
        end
        else
        begin
            probe_reg.active <= probe_in.active;
            if (probe_in.active)
            begin
                probe_reg.hit       <= probe_in.hit | match;
                probe_reg.free_seen <= probe_in.free_seen | ~valid_reg;
                mark_hit_reg        <= match;
                mark_free_reg       <= ~valid_reg & ~probe_in.free_seen;
            end
        end
    end

    assign probe_out = probe_reg;

    // Entry update at commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (commit.insert_en && mark_free_reg)
        begin
            valid_reg <= 1'b1;
        end
        else if (commit.erase_en && mark_hit_reg)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Stored key; ignored while invalid
    always_ff @(posedge clk)
    begin
        if (commit.insert_en && mark_free_reg)
        begin
            value_reg <= key;
        end
    end

endmodule

// ===== hw/rtl/smt_ctrl.sv =====
// Sequencer: takes an item, launches the probe, commits the update and holds the result.
module smt_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [smt_pkg::CMD_W-1:0]   command,
    input  logic signed [smt_pkg::KEY_W-1:0] value,
    output logic [smt_pkg::KEY_W-1:0]   key,
    output smt_pkg::probe_t             launch,
    input  smt_pkg::probe_t             tail,
    output smt_pkg::commit_t            commit,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic                        overflow
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [smt_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [smt_pkg::KEY_W-1:0]   key_reg, key_next;
    logic                        launch_reg, launch_next;
    logic                        hit_reg, hit_next;
    logic                        free_reg, free_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        found_reg, found_next;
    logic                        overflow_reg, overflow_next;
    logic                        commit_go;
    logic                        is_insert;
    logic                        is_erase;

    assign in_ready  = (state_reg == ST_IDLE);
    assign is_insert = (cmd_reg == smt_pkg::CMD_INSERT);
    assign is_erase  = (cmd_reg == smt_pkg::CMD_ERASE);

    // Commit once the output slot is free
    assign commit_go        = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);
    assign commit.insert_en = commit_go && is_insert && !hit_reg && free_reg;
    assign commit.erase_en  = commit_go && is_erase && hit_reg;

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        launch_next    = 1'b0;
        hit_next       = hit_reg;
        free_next      = free_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        overflow_next  = overflow_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = command;
                    key_next    = value;
                    launch_next = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Summary arrives at the end of the chain
                if (tail.active)
                begin
                    hit_next   = tail.hit;
                    free_next  = tail.free_seen;
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (commit_go)
                begin
                    out_valid_next = 1'b1;
                    found_next     = (cmd_reg != smt_pkg::CMD_UNUSED) && hit_reg;
                    overflow_next  = is_insert && !hit_reg && !free_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= smt_pkg::CMD_QUERY;
            key_reg       <= '0;
            launch_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            key_reg       <= key_next;
            launch_reg    <= launch_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            overflow_reg  <= overflow_next;
        end
    end

    assign key              = key_reg;
    assign launch.active    = launch_reg;
    assign launch.hit       = 1'b0;
    assign launch.free_seen = 1'b0;
    assign out_valid        = out_valid_reg;
    assign found            = found_reg;
    assign overflow         = overflow_reg;

endmodule

// ===== hw/rtl/set_membership_table.sv =====
// Top level of the set membership table: sequencer and chain of entry cells.
//
// Holds up to CAPACITY distinct 32-bit signed keys. Each item (insert, erase or
// query) gives one result: found says the key was present before the item, and
// overflow flags an insert dropped because every entry was in use. A probe token
// walks the chain of cells one cell per clock, each cell comparing its entry with
// the key and marking itself as the match or as the first free entry; the
// sequencer then takes the summary from the end of the chain and, in its commit
// state, applies the update and registers the result. A new item is taken only
// while the sequencer is idle, so items do not overlap in the chain. A waiting
// result holds back the commit of the following item. The table is empty after
// reset, with no clearing pass.
module set_membership_table #(
    parameter int CAPACITY = smt_pkg::CAPACITY
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [smt_pkg::CMD_W-1:0]        command,
    input  logic signed [smt_pkg::KEY_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic                             overflow
);

    smt_pkg::probe_t           chain [0:CAPACITY];
    smt_pkg::commit_t          commit;
    logic [smt_pkg::KEY_W-1:0] key;

    // Sequencer
    smt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .value     (value),
        .key       (key),
        .launch    (chain[0]),
        .tail      (chain[CAPACITY]),
        .commit    (commit),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .overflow  (overflow)
    );

    // Row of entry cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        smt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .probe_in  (chain[i]),
            .probe_out (chain[i+1]),
            .key       (key),
            .commit    (commit)
        );
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the set membership table: table model, stimulus and result checks.
`timescale 1ns / 100ps

module tb;

    localparam int ITEM_TARGET   = 1000;
    localparam int POOL_SIZE     = 80;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = smt_pkg::CAPACITY + 10;

    // One expected result, with the item that caused it for reporting
    typedef struct {
        logic [smt_pkg::CMD_W-1:0] cmd;
        logic [smt_pkg::KEY_W-1:0] key;
        logic                      found;
        logic                      overflow;
    } membership_result_t;

    // Table model and queue of expected results
    class membership_scoreboard;
        logic [smt_pkg::KEY_W-1:0] slot_key [smt_pkg::CAPACITY];
        bit                        slot_used [smt_pkg::CAPACITY];
        membership_result_t        expected_results [$];
        int                        mismatches;
        int                        results_seen;

        function new();
            for (int i = 0; i < smt_pkg::CAPACITY; i++)
            begin
                slot_key[i]  = '0;
                slot_used[i] = 1'b0;
            end
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // Work out the result of an accepted item and update the table
        function void note_item(logic [smt_pkg::CMD_W-1:0] cmd,
                                logic [smt_pkg::KEY_W-1:0] key);
            int                 hit;
            int                 free_idx;
            membership_result_t want;
            hit      = -1;
            free_idx = -1;
            for (int i = 0; i < smt_pkg::CAPACITY; i++)
            begin
                if (slot_used[i] && slot_key[i] == key && hit < 0)
                    hit = i;
                if (!slot_used[i] && free_idx < 0)
                    free_idx = i;
            end
            want.cmd      = cmd;
            want.key      = key;
            want.found    = 1'b0;
            want.overflow = 1'b0;
            case (cmd)
                smt_pkg::CMD_INSERT:
                begin
                    want.found = (hit >= 0);
                    if (hit < 0)
                    begin
                        if (free_idx >= 0)
                        begin
                            slot_key[free_idx]  = key;
                            slot_used[free_idx] = 1'b1;
                        end
                        else
                            want.overflow = 1'b1;
                    end
                end
                smt_pkg::CMD_ERASE:
                begin
                    want.found = (hit >= 0);
                    if (hit >= 0)
                    begin
                        slot_used[hit] = 1'b0;
                        slot_key[hit]  = '0;
                    end
                end
                smt_pkg::CMD_QUERY:
                    want.found = (hit >= 0);
                default:
                    ;  // unused code: nothing changes, both flags low
            endcase
            expected_results = {expected_results, want};
        endfunction

        // Compare an accepted result with the oldest expectation
        function void check_result(logic got_found, logic got_overflow);
            membership_result_t want;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with nothing expected: found=%b overflow=%b",
                             results_seen, got_found, got_overflow);
                return;
            end
            want = expected_results.pop_front();
            if (got_found !== want.found || got_overflow !== want.overflow)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch on result %0d (cmd %0d key %h): ",
                              "found exp %b got %b, overflow exp %b got %b"},
                             results_seen, want.cmd, want.key, want.found, got_found,
                             want.overflow, got_overflow);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function int live_count();
            int n;
            n = 0;
            for (int i = 0; i < smt_pkg::CAPACITY; i++)
                if (slot_used[i])
                    n++;
            return n;
        endfunction

        // A key currently held, picked at random (table must not be empty)
        function logic [smt_pkg::KEY_W-1:0] live_key();
            int pick;
            pick = $urandom_range(0, live_count() - 1);
            for (int i = 0; i < smt_pkg::CAPACITY; i++)
            begin
                if (slot_used[i])
                begin
                    if (pick == 0)
                        return slot_key[i];
                    pick--;
                end
            end
            return '0;
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [smt_pkg::CMD_W-1:0]        command = smt_pkg::CMD_INSERT;
    logic signed [smt_pkg::KEY_W-1:0] value = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic                             found;
    logic                             overflow;

    membership_scoreboard sb;
    int                   cycle_count = 0;

    set_membership_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .overflow  (overflow)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Present one item and hold it until accepted
    task automatic send_item(logic [smt_pkg::CMD_W-1:0] cmd, logic [smt_pkg::KEY_W-1:0] key);
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= key;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sb.note_item(cmd, key);
    endtask

    task automatic idle_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold off until every expected result has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Receiver: check results, stall on a rotating pattern
    initial
    begin : receiver
        logic [7:0] stall_pattern;
        int         pos;
        int         mode_left;
        stall_pattern = 8'hFF;
        pos           = 0;
        mode_left     = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(found, overflow);
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(50, 400);
                if ($urandom_range(0, 2) == 0)
                    stall_pattern = 8'hFF;
                else
                    stall_pattern = 8'($urandom_range(1, 255));
            end
            mode_left--;
            out_ready <= stall_pattern[pos];
            pos = (pos + 1) % 8;
        end
    end

    // Stimulus
    initial
    begin : stimulus
        logic [smt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
        logic [smt_pkg::CMD_W-1:0] cmd;
        logic [smt_pkg::KEY_W-1:0] key;
        int                        sent;
        int                        phase_kind;
        int                        phase_len;
        int                        burst_left;
        int                        roll;
        bit                        no_gaps;
        int                        ins_lim;
        int                        era_lim;
        int                        qry_lim;

        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, duplicates, absent keys, unused code
        send_item(smt_pkg::CMD_QUERY,  32'h0000_0000);
        send_item(smt_pkg::CMD_INSERT, 32'h8000_0000);
        send_item(smt_pkg::CMD_INSERT, 32'h7FFF_FFFF);
        send_item(smt_pkg::CMD_INSERT, 32'h0000_0000);
        send_item(smt_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        send_item(smt_pkg::CMD_INSERT, 32'h8000_0000);
        send_item(smt_pkg::CMD_QUERY,  32'h7FFF_FFFF);
        send_item(smt_pkg::CMD_QUERY,  32'h0000_0001);
        send_item(smt_pkg::CMD_ERASE,  32'h0000_0000);
        send_item(smt_pkg::CMD_ERASE,  32'h0000_0000);
        send_item(smt_pkg::CMD_QUERY,  32'h0000_0000);
        send_item(smt_pkg::CMD_UNUSED, 32'hFFFF_FFFF);
        send_item(smt_pkg::CMD_QUERY,  32'hFFFF_FFFF);
        send_item(smt_pkg::CMD_UNUSED, 32'h0000_0005);
        send_item(smt_pkg::CMD_QUERY,  32'h0000_0005);
        send_item(smt_pkg::CMD_INSERT, 32'h0000_0000);
        send_item(smt_pkg::CMD_QUERY,  32'h8000_0000);
        send_item(smt_pkg::CMD_ERASE,  32'h7FFF_FFFF);
        send_item(smt_pkg::CMD_ERASE,  32'hFFFF_FFFF);
        send_item(smt_pkg::CMD_ERASE,  32'h8000_0000);
        send_item(smt_pkg::CMD_ERASE,  32'h0000_0000);
        wait_for_drain();

        // Key pool: extremes, single-bit neighbours, small and random keys
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        key_pool[5] = 32'h8000_0001;
        for (int i = 6; i < POOL_SIZE; i++)
        begin
            case (i % 4)
                0: key_pool[i] = $urandom_range(0, 40);
                1: key_pool[i] = -$urandom_range(1, 40);
                2: key_pool[i] = key_pool[i - 1] ^ (32'h1 << $urandom_range(0, 31));
                default: key_pool[i] = $urandom;
            endcase
        end

        // Random phases: filling, draining or mixed traffic
        sent       = 0;
        burst_left = 0;
        while (sent < ITEM_TARGET)
        begin
            phase_kind = $urandom_range(0, 2);
            phase_len  = $urandom_range(60, 250);
            no_gaps    = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                wait_for_drain();
            case (phase_kind)
                0:
                begin
                    ins_lim = 70;
                    era_lim = 80;
                    qry_lim = 95;
                end
                1:
                begin
                    ins_lim = 15;
                    era_lim = 70;
                    qry_lim = 95;
                end
                default:
                begin
                    ins_lim = 35;
                    era_lim = 65;
                    qry_lim = 95;
                end
            endcase
            for (int n = 0; n < phase_len && sent < ITEM_TARGET; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < ins_lim)
                    cmd = smt_pkg::CMD_INSERT;
                else if (roll < era_lim)
                    cmd = smt_pkg::CMD_ERASE;
                else if (roll < qry_lim)
                    cmd = smt_pkg::CMD_QUERY;
                else
                    cmd = smt_pkg::CMD_UNUSED;

                roll = $urandom_range(0, 99);
                if (cmd != smt_pkg::CMD_INSERT && roll < 40 && sb.live_count() > 0)
                    key = sb.live_key();
                else if (roll < 90)
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    key = $urandom;

                // Bursts with random gaps between them
                if (!no_gaps)
                begin
                    if (burst_left == 0)
                    begin
                        idle_sender($urandom_range(1, 100));
                        burst_left = $urandom_range(1, 12);
                    end
                    burst_left--;
                end

                send_item(cmd, key);
                if (cmd != smt_pkg::CMD_UNUSED)
                    sent++;
            end
        end

        // Let the last results come back, then settle
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/smt_pkg.sv
hw/rtl/smt_cell.sv
hw/rtl/smt_ctrl.sv
hw/rtl/set_membership_table.sv
tb/sv/tb.sv
